### hdl/twt_pkg.sv
// Shared types, constants and byte-class helpers for the word tokenizer.
// Used by twt_front, twt_queue, twt_back and text_word_tokenizer_unit.
`default_nettype none

package twt_pkg;

  // fixed field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 8;
  localparam int LANE_MAX_W = 3;
  localparam int CFG_W      = 4;
  localparam int CNT_W      = 4;
  localparam int CHUNK_W    = 64;
  localparam int OUT_TDATA_W = 72;

  // byte codes
  localparam logic [BYTE_W-1:0] CH_HYPHEN   = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_APOS     = 8'h27;
  localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5a;
  localparam logic [BYTE_W-1:0] CH_LOWER_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z  = 8'h7a;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  localparam logic [CFG_W-1:0] MIN_LEN_RESET = 4'd2;

  // buffer write from front to back
  typedef struct packed {
    logic                  en;
    logic                  bank;
    logic [LEN_W-1:0]      row;
    logic [LANE_MAX_W-1:0] lane;
    logic [BYTE_W-1:0]     data;
  } twt_wr_t;

  // finished token handed to the back part
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } twt_desc_t;

  // bank released by the back part
  typedef struct packed {
    logic valid;
    logic bank;
  } twt_done_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_upper(input logic [BYTE_W-1:0] b);
    return (b >= CH_UPPER_A) && (b <= CH_UPPER_Z);
  endfunction

  function automatic logic is_lower(input logic [BYTE_W-1:0] b);
    return (b >= CH_LOWER_A) && (b <= CH_LOWER_Z);
  endfunction

endpackage

`default_nettype wire

### hdl/twt_front.sv
// Front part: accepts text bytes, classifies them, tracks the open token and
// writes its bytes into the token buffer. Depends on twt_pkg.
`default_nettype none

module twt_front #(
  parameter int MAX_TOKEN_BYTES = 250,
  parameter int CHUNK_BYTES     = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_wen_i,
  input  wire  [twt_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [twt_pkg::BYTE_W-1:0]       in_byte_i,
  input  wire                              in_eod_i,
  output twt_pkg::twt_wr_t                 wr_o,
  output logic                             push_o,
  output twt_pkg::twt_desc_t               push_desc_o,
  input  wire                              q_full_i,
  input  twt_pkg::twt_done_t               done_i
);

  localparam int ROWS   = (MAX_TOKEN_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam logic [twt_pkg::LEN_W-1:0] MAX_LEN   = twt_pkg::LEN_W'(MAX_TOKEN_BYTES);
  localparam logic [LANE_W-1:0]         LAST_LANE = LANE_W'(CHUNK_BYTES - 1);

  logic [twt_pkg::LEN_W-1:0] len_q, len_d;
  logic                      pend_q, pend_d;
  logic                      alld_q, alld_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [LANE_W-1:0]         lane_q, lane_d;
  logic                      wb_q, wb_d;
  logic [1:0]                busy_q, busy_d;
  logic [twt_pkg::CFG_W-1:0] min_q;

  logic [ROW_W-1:0]          row1, row2;
  logic [LANE_W-1:0]         lane1, lane2;
  logic                      fire;

  // next two byte positions after the current one
  always_comb begin
    if (lane_q == LAST_LANE) begin
      row1  = row_q + ROW_W'(1);
      lane1 = '0;
    end else begin
      row1  = row_q;
      lane1 = lane_q + LANE_W'(1);
    end
    if (lane1 == LAST_LANE) begin
      row2  = row1 + ROW_W'(1);
      lane2 = '0;
    end else begin
      row2  = row1;
      lane2 = lane1 + LANE_W'(1);
    end
  end

  assign in_ready_o = !busy_q[wb_q] && !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  // token tracking for one accepted byte
  always_comb begin
    logic                      word;
    logic                      joiner;
    logic                      dig;
    logic                      finish;
    logic                      kept;
    logic [twt_pkg::BYTE_W-1:0] folded;

    dig    = twt_pkg::is_digit(in_byte_i);
    word   = dig || twt_pkg::is_upper(in_byte_i) || twt_pkg::is_lower(in_byte_i);
    joiner = (in_byte_i == twt_pkg::CH_HYPHEN) || (in_byte_i == twt_pkg::CH_APOS);
    folded = twt_pkg::is_upper(in_byte_i) ? in_byte_i + twt_pkg::CASE_OFFSET : in_byte_i;
    finish = 1'b0;
    kept   = 1'b0;

    len_d  = len_q;
    pend_d = pend_q;
    alld_d = alld_q;
    row_d  = row_q;
    lane_d = lane_q;
    wb_d   = wb_q;
    busy_d = busy_q;

    wr_o.en   = 1'b0;
    wr_o.bank = wb_q;
    wr_o.row  = twt_pkg::LEN_W'(row_q);
    wr_o.lane = twt_pkg::LANE_MAX_W'(lane_q);
    wr_o.data = folded;

    push_o           = 1'b0;
    push_desc_o.bank = wb_q;
    push_desc_o.len  = '0;

    if (fire) begin
      if (pend_q && !word) begin
        finish = 1'b1;
      end else if (word) begin
        wr_o.en = 1'b1;
        if (pend_q) begin
          // joiner already sits at the current position
          wr_o.row  = twt_pkg::LEN_W'(row1);
          wr_o.lane = twt_pkg::LANE_MAX_W'(lane1);
          len_d     = len_q + twt_pkg::LEN_W'(2);
          alld_d    = 1'b0;
          row_d     = row2;
          lane_d    = lane2;
        end else begin
          len_d  = len_q + twt_pkg::LEN_W'(1);
          alld_d = alld_q && dig;
          row_d  = row1;
          lane_d = lane1;
        end
        pend_d = 1'b0;
        if (len_d >= MAX_LEN) begin
          finish = 1'b1;
        end
      end else if (joiner && (len_q != '0)) begin
        if (len_q + twt_pkg::LEN_W'(1) >= MAX_LEN) begin
          finish = 1'b1;
        end else begin
          // park the joiner at the next slot, length unchanged
          pend_d  = 1'b1;
          wr_o.en = 1'b1;
        end
      end else if (len_q != '0) begin
        finish = 1'b1;
      end

      if (in_eod_i) begin
        finish = 1'b1;
      end

      if (finish) begin
        kept = (len_d != '0) && (len_d >= twt_pkg::LEN_W'(min_q)) && !alld_d;
        if (kept) begin
          push_o          = 1'b1;
          push_desc_o.len = len_d;
          busy_d[wb_q]    = 1'b1;
          wb_d            = !wb_q;
        end
        len_d  = '0;
        pend_d = 1'b0;
        alld_d = 1'b1;
        row_d  = '0;
        lane_d = '0;
      end
    end

    // release of a drained bank
    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      pend_q <= 1'b0;
      alld_q <= 1'b1;
      row_q  <= '0;
      lane_q <= '0;
      wb_q   <= 1'b0;
      busy_q <= '0;
      min_q  <= twt_pkg::MIN_LEN_RESET;
    end else begin
      len_q  <= len_d;
      pend_q <= pend_d;
      alld_q <= alld_d;
      row_q  <= row_d;
      lane_q <= lane_d;
      wb_q   <= wb_d;
      busy_q <= busy_d;
      if (cfg_wen_i) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/twt_queue.sv
// Two-entry queue of finished token descriptors between front and back.
// Depends on twt_pkg.
`default_nettype none

module twt_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  twt_pkg::twt_desc_t  push_desc_i,
  output logic                full_o,
  output logic                valid_o,
  output twt_pkg::twt_desc_t  head_o,
  input  wire                 pop_i
);

  twt_pkg::twt_desc_t entry_q [2];
  logic               wptr_q, rptr_q;
  logic [1:0]         count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_desc_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/twt_back.sv
// Back part: holds the two-bank token buffer and drains finished tokens as
// chunks into the output register. Depends on twt_pkg.
`default_nettype none

module twt_back #(
  parameter int MAX_TOKEN_BYTES = 250,
  parameter int CHUNK_BYTES     = 8
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  twt_pkg::twt_wr_t                      wr_i,
  input  wire                                   q_valid_i,
  input  twt_pkg::twt_desc_t                    q_head_i,
  output logic                                  q_pop_o,
  output twt_pkg::twt_done_t                    done_o,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic [twt_pkg::CHUNK_W-1:0]           out_chunk_o,
  output logic [twt_pkg::CNT_W-1:0]             out_cnt_o,
  output logic                                  out_last_o
);

  localparam int ROWS   = (MAX_TOKEN_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int ADDR_W = ROW_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam logic [twt_pkg::LEN_W-1:0] CHUNK_LEN = twt_pkg::LEN_W'(CHUNK_BYTES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [twt_pkg::BYTE_W-1:0] mem_q [CHUNK_BYTES][DEPTH];
  logic [twt_pkg::BYTE_W-1:0] rd_q  [CHUNK_BYTES];

  logic                      state_q, state_d;
  logic                      bank_q, bank_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [twt_pkg::LEN_W-1:0] rem_q, rem_d;

  logic                       out_valid_q;
  logic [twt_pkg::CHUNK_W-1:0] out_chunk_q;
  logic [twt_pkg::CNT_W-1:0]  out_cnt_q;
  logic                       out_last_q;

  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          wr_addr;
  logic [LANE_W-1:0]          wr_lane;
  logic                       out_free;
  logic                       load;
  logic [twt_pkg::CNT_W-1:0]  take;
  logic                       is_last;
  logic [twt_pkg::CHUNK_W-1:0] chunk_d;

  assign wr_addr = {wr_i.bank, wr_i.row[ROW_W-1:0]};
  assign wr_lane = wr_i.lane[LANE_W-1:0];

  // token buffer, one byte lane per chunk position
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      if (wr_i.en && (wr_lane == LANE_W'(k))) begin
        mem_q[k][wr_addr] <= wr_i.data;
      end
      if (rd_en) begin
        rd_q[k] <= mem_q[k][rd_addr];
      end
    end
  end

  // chunk size and masking of the read row
  assign take    = (rem_q >= CHUNK_LEN) ? twt_pkg::CNT_W'(CHUNK_BYTES)
                                        : rem_q[twt_pkg::CNT_W-1:0];
  assign is_last = (rem_q <= CHUNK_LEN);

  always_comb begin
    chunk_d = '0;
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      if (twt_pkg::CNT_W'(k) < take) begin
        chunk_d[8*k +: 8] = rd_q[k];
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // drain sequencer
  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    row_d       = row_q;
    rem_d       = rem_q;
    rd_en       = 1'b0;
    rd_addr     = {bank_q, row_q};
    q_pop_o     = 1'b0;
    load        = 1'b0;
    done_o.valid = 1'b0;
    done_o.bank  = bank_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          bank_d  = q_head_i.bank;
          rem_d   = q_head_i.len;
          row_d   = '0;
          rd_en   = 1'b1;
          rd_addr = {q_head_i.bank, {ROW_W{1'b0}}};
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          load  = 1'b1;
          rem_d = rem_q - twt_pkg::LEN_W'(take);
          if (is_last) begin
            done_o.valid = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            row_d   = row_q + ROW_W'(1);
            rd_en   = 1'b1;
            rd_addr = {bank_q, row_q + ROW_W'(1)};
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sequencer payload and output register
  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
    row_q  <= row_d;
    rem_q  <= rem_d;
    if (load) begin
      out_chunk_q <= chunk_d;
      out_cnt_q   <= take;
      out_last_q  <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_chunk_o = out_chunk_q;
  assign out_cnt_o   = out_cnt_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

### hdl/text_word_tokenizer_unit.sv
// Top level of the word tokenizer: front classifier, descriptor queue and
// chunk drain. Depends on twt_pkg, twt_front, twt_queue and twt_back.
//
// Usage:
//   s_axis carries one document byte per transaction (tlast marks the last byte
//   of a document). m_axis carries token chunks of up to CHUNK_BYTES bytes,
//   first byte lowest; tlast marks the final chunk of a token. cfg_wen_i writes
//   min_token_length from cfg_wdata_i; only the user keeps this to idle time.
// Throughput: one byte per cycle on the input; tokens are written into a
//   two-bank buffer, so input stalls only while both banks still drain.
//   Output drains one chunk per cycle while m_axis_tready is high and pauses
//   between tokens for the registered read of the token buffer.
// Path: after the byte that ends a token is accepted, its first chunk passes
//   the descriptor queue, the registered buffer read and the output register.
// Reset: asynchronous, active low; clears the open token, both bank flags, the
//   queue and sets min_token_length to 2. No clearing pass is needed.
// Stall: when m_axis_tready is low the chunk holds in the output register;
//   the front keeps taking bytes until both buffer banks are occupied.
`default_nettype none

module text_word_tokenizer_unit #(
  parameter int MAX_TOKEN_BYTES = 250,
  parameter int CHUNK_BYTES     = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration
  input  wire                                  cfg_wen_i,
  input  wire  [twt_pkg::CFG_W-1:0]            cfg_wdata_i,
  // input stream
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [7:0]                           s_axis_tdata,  // [7:0] text_byte
  input  wire                                  s_axis_tlast,  // end_of_document
  // output stream
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // [63:0] token_chunk, [67:64] bytes_valid, [71:68] zero
  output logic [twt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast   // last_chunk
);

  twt_pkg::twt_wr_t    wr;
  twt_pkg::twt_desc_t  push_desc;
  twt_pkg::twt_desc_t  head;
  twt_pkg::twt_done_t  done;
  logic                push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic [twt_pkg::CHUNK_W-1:0] chunk;
  logic [twt_pkg::CNT_W-1:0]   cnt;

  // byte classification and token build
  twt_front #(
    .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES),
    .CHUNK_BYTES     (CHUNK_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wen_i   (cfg_wen_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eod_i    (s_axis_tlast),
    .wr_o        (wr),
    .push_o      (push),
    .push_desc_o (push_desc),
    .q_full_i    (q_full),
    .done_i      (done)
  );

  // finished tokens waiting to drain
  twt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head),
    .pop_i       (q_pop)
  );

  // chunk emission
  twt_back #(
    .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES),
    .CHUNK_BYTES     (CHUNK_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .q_pop_o     (q_pop),
    .done_o      (done),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_chunk_o (chunk),
    .out_cnt_o   (cnt),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, cnt, chunk};

endmodule

`default_nettype wire
